/* hdl/tcsm_pkg.sv */
`timescale 1ns / 1ps

package tcsm_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned MaxResults = 3;
  localparam logic [15:0] RecvWindowReset = 16'hFFFF;

  typedef enum logic [3:0] {
    ACT_DROP    = 4'd0,
    ACT_ACK     = 4'd1,
    ACT_RESET   = 4'd2,
    ACT_SYN     = 4'd3,
    ACT_FIN     = 4'd4,
    ACT_DATA    = 4'd5,
    ACT_DELIVER = 4'd6,
    ACT_HOLD    = 4'd7,
    ACT_SPAWN   = 4'd8,
    ACT_CLOSED  = 4'd9
  } action_e;

  typedef enum logic [2:0] {
    KIND_SEGMENT = 3'd0,
    KIND_OPEN    = 3'd1,
    KIND_CLOSE   = 3'd2,
    KIND_TW_EXP  = 3'd3,
    KIND_SEND    = 3'd4
  } kind_e;

  typedef enum logic {
    REG_RECV_WINDOW  = 1'b0,
    REG_PASSIVE_OPEN = 1'b1
  } reg_idx_e;

  typedef struct packed {
    action_e     action;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [15:0] len;
  } res_t;

  typedef struct packed {
    res_t [MaxResults-1:0] res;
    logic [1:0]            cnt;
    logic [3:0]            conn_state;
  } bundle_t;

  function automatic res_t mk_res(action_e a, logic [31:0] s, logic [31:0] k,
                                  logic [15:0] l);
    res_t r;
    r.action = a;
    r.seq    = s;
    r.ack    = k;
    r.len    = l;
    return r;
  endfunction

endpackage

/* hdl/tcsm_front.sv */
`timescale 1ns / 1ps

module tcsm_front import tcsm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  kind_i,
  input  logic [31:0] seg_seq_i,
  input  logic [31:0] seg_ack_i,
  input  logic        flag_syn_i,
  input  logic        flag_ack_i,
  input  logic        flag_fin_i,
  input  logic        flag_rst_i,
  input  logic [15:0] payload_len_i,
  input  logic [31:0] initial_seq_i,
  input  logic        q_full_i,
  output logic        push_o,
  output bundle_t     push_data_o
);

  typedef enum logic [3:0] {
    ST_CLOSED     = 4'd0,
    ST_LISTEN     = 4'd1,
    ST_SYN_SENT   = 4'd2,
    ST_SYN_RCVD   = 4'd3,
    ST_ESTAB      = 4'd4,
    ST_FIN_WAIT_1 = 4'd5,
    ST_FIN_WAIT_2 = 4'd6,
    ST_CLOSE_WAIT = 4'd7,
    ST_CLOSING    = 4'd8,
    ST_LAST_ACK   = 4'd9,
    ST_TIME_WAIT  = 4'd10
  } conn_state_e;

  conn_state_e state_q, state_d;
  logic [31:0] nss_q, nss_d, ous_q, ous_d, ers_q, ers_d;
  logic        fin_seen_q, fin_seen_d, rst_seen_q, rst_seen_d;
  logic [15:0] win_q;
  logic        po_q;

  res_t [MaxResults-1:0] r;
  logic [1:0]            n;
  logic                  accept, done, win_bad;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d    = state_q;
    nss_d      = nss_q;
    ous_d      = ous_q;
    ers_d      = ers_q;
    fin_seen_d = fin_seen_q;
    rst_seen_d = rst_seen_q;
    r          = '0;
    n          = 2'd0;
    done       = 1'b0;
    win_bad    = (seg_seq_i < ers_q) ||
                 ({1'b0, seg_seq_i} > ({1'b0, ers_q} + {17'd0, win_q}));
    unique case (kind_i)
      KIND_SEGMENT: begin
        if (state_q == ST_CLOSED) begin
          if (!flag_rst_i) begin
            ers_d = nss_q;
            r[n] = mk_res(ACT_RESET, nss_q, nss_q, 16'd0); n = n + 2'd1;
          end
        end else if (state_q == ST_LISTEN) begin
          if (!flag_rst_i) begin
            if (flag_ack_i || !flag_syn_i) begin
              ers_d = nss_q;
              r[n] = mk_res(ACT_RESET, nss_q, nss_q, 16'd0); n = n + 2'd1;
            end else begin
              r[n] = mk_res(ACT_SPAWN, initial_seq_i, seg_seq_i + 32'd1, 16'd0);
              n = n + 2'd1;
            end
          end
        end else if (state_q == ST_SYN_SENT) begin
          if (flag_rst_i) begin
            rst_seen_d = 1'b1;
            state_d = ST_CLOSED;
            r[n] = mk_res(ACT_CLOSED, '0, '0, '0); n = n + 2'd1;
          end else if (flag_ack_i && flag_syn_i && seg_ack_i == nss_q) begin
            ers_d = seg_seq_i + 32'd1;
            ous_d = seg_ack_i;
            r[n] = mk_res(ACT_ACK, nss_q, ers_d, 16'd0); n = n + 2'd1;
            state_d = ST_ESTAB;
          end
        end else if (win_bad) begin
          r[n] = mk_res(ACT_ACK, nss_q, ers_q, 16'd0); n = n + 2'd1;
        end else if (seg_ack_i < ous_q || seg_ack_i > nss_q) begin
          // out of range ack: drop
        end else if (flag_rst_i) begin
          rst_seen_d = 1'b1;
          state_d = ST_CLOSED;
          r[n] = mk_res(ACT_CLOSED, '0, '0, '0); n = n + 2'd1;
        end else if (!flag_ack_i || flag_syn_i) begin
          ers_d = nss_q;
          r[n] = mk_res(ACT_RESET, nss_q, nss_q, 16'd0); n = n + 2'd1;
        end else begin
          if (flag_fin_i) begin
            if (seg_ack_i > ous_d) ous_d = seg_ack_i;
            if (seg_seq_i != ers_q) begin
              done = 1'b1;
            end else if (state_q == ST_ESTAB || state_q == ST_SYN_RCVD ||
                         state_q == ST_FIN_WAIT_1 || state_q == ST_FIN_WAIT_2) begin
              fin_seen_d = 1'b1;
              ers_d = ers_q + {16'd0, payload_len_i} + 32'd1;
              r[n] = mk_res(ACT_ACK, nss_q, ers_d, 16'd0); n = n + 2'd1;
              state_d = (state_q == ST_ESTAB || state_q == ST_SYN_RCVD) ?
                        ST_CLOSE_WAIT : ST_TIME_WAIT;
              if (payload_len_i != 16'd0) begin
                r[n] = mk_res(ACT_DELIVER, seg_seq_i, '0, payload_len_i);
                n = n + 2'd1;
              end
              done = 1'b1;
            end else if (state_q == ST_TIME_WAIT) begin
              r[n] = mk_res(ACT_ACK, nss_q, ers_q, 16'd0); n = n + 2'd1;
              done = 1'b1;
            end
          end
          if (!done) begin
            if (state_q == ST_SYN_RCVD) begin
              if (seg_seq_i == ers_q && seg_ack_i == nss_q) state_d = ST_ESTAB;
            end else if (state_q == ST_CLOSE_WAIT || state_q == ST_LAST_ACK) begin
              if (payload_len_i != 16'd0 && seg_seq_i >= ers_q) begin
                ers_d = nss_q;
                r[n] = mk_res(ACT_RESET, nss_q, nss_q, 16'd0); n = n + 2'd1;
                state_d = ST_CLOSED;
                r[n] = mk_res(ACT_CLOSED, '0, '0, '0); n = n + 2'd1;
              end else begin
                if (seg_ack_i > ous_d && seg_ack_i <= nss_q) ous_d = seg_ack_i;
                if (state_q == ST_LAST_ACK && ous_d == nss_q) begin
                  state_d = ST_CLOSED;
                  r[n] = mk_res(ACT_CLOSED, '0, '0, '0); n = n + 2'd1;
                end
              end
            end else if (state_q == ST_ESTAB || state_q == ST_FIN_WAIT_1 ||
                         state_q == ST_FIN_WAIT_2) begin
              if (seg_ack_i > ous_d) begin
                ous_d = seg_ack_i;
                if (state_d == ST_FIN_WAIT_1) state_d = ST_FIN_WAIT_2;
              end
              if (payload_len_i != 16'd0) begin
                if (state_d != ST_ESTAB) begin
                  ers_d = nss_q;
                  r[n] = mk_res(ACT_RESET, nss_q, nss_q, 16'd0); n = n + 2'd1;
                  state_d = ST_CLOSED;
                  r[n] = mk_res(ACT_CLOSED, '0, '0, '0); n = n + 2'd1;
                end else if (seg_seq_i == ers_q) begin
                  ers_d = seg_seq_i + {16'd0, payload_len_i};
                  r[n] = mk_res(ACT_DELIVER, seg_seq_i, '0, payload_len_i);
                  n = n + 2'd1;
                end else begin
                  r[n] = mk_res(ACT_HOLD, seg_seq_i, '0, payload_len_i);
                  n = n + 2'd1;
                end
              end
            end
          end
        end
      end
      KIND_OPEN: begin
        if (state_q == ST_CLOSED || state_q == ST_LISTEN || state_q == ST_SYN_RCVD) begin
          fin_seen_d = 1'b0;
          rst_seen_d = 1'b0;
          ous_d = initial_seq_i;
          nss_d = initial_seq_i + 32'd1;
          state_d = ST_SYN_SENT;
          r[n] = mk_res(ACT_SYN, initial_seq_i, ers_q, 16'd0); n = n + 2'd1;
        end
      end
      KIND_CLOSE: begin
        if (state_q == ST_CLOSED) begin
          r[n] = mk_res(ACT_CLOSED, '0, '0, '0); n = n + 2'd1;
        end else if (state_q == ST_SYN_SENT || state_q == ST_SYN_RCVD ||
                     state_q == ST_ESTAB || state_q == ST_CLOSE_WAIT) begin
          r[n] = mk_res(ACT_FIN, nss_q, ers_q, 16'd0); n = n + 2'd1;
          nss_d = nss_q + 32'd1;
          state_d = (state_q == ST_CLOSE_WAIT) ? ST_LAST_ACK : ST_FIN_WAIT_1;
        end
      end
      KIND_TW_EXP: begin
        if (state_q == ST_TIME_WAIT) begin
          state_d = ST_CLOSED;
          r[n] = mk_res(ACT_CLOSED, '0, '0, '0); n = n + 2'd1;
        end
      end
      KIND_SEND: begin
        if ((state_q == ST_ESTAB || state_q == ST_CLOSE_WAIT) &&
            payload_len_i != 16'd0) begin
          r[n] = mk_res(ACT_DATA, nss_q, ers_q, payload_len_i); n = n + 2'd1;
          nss_d = nss_q + {16'd0, payload_len_i};
        end
      end
      default: ;
    endcase
    // every item yields at least one result
    if (n == 2'd0) begin
      r[0] = mk_res(ACT_DROP, '0, '0, '0);
      n = 2'd1;
    end
  end

  assign push_o                 = accept;
  assign push_data_o.res        = r;
  assign push_data_o.cnt        = n;
  assign push_data_o.conn_state = state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLOSED;
      nss_q      <= '0;
      ous_q      <= '0;
      ers_q      <= '0;
      fin_seen_q <= 1'b0;
      rst_seen_q <= 1'b0;
      win_q      <= RecvWindowReset;
      po_q       <= 1'b0;
    end else if (accept) begin
      state_q    <= state_d;
      nss_q      <= nss_d;
      ous_q      <= ous_d;
      ers_q      <= ers_d;
      fin_seen_q <= fin_seen_d;
      rst_seen_q <= rst_seen_d;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_RECV_WINDOW) begin
        win_q <= cfg_wdata_i;
      end else begin
        po_q <= cfg_wdata_i[0];
        if (state_q == ST_CLOSED || state_q == ST_LISTEN)
          state_q <= cfg_wdata_i[0] ? ST_LISTEN : ST_CLOSED;
      end
    end
  end

endmodule

/* hdl/tcsm_queue.sv */
`timescale 1ns / 1ps

module tcsm_queue import tcsm_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  bundle_t push_data_i,
  input  logic    pop_i,
  output logic    full_o,
  output logic    empty_o,
  output bundle_t head_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  bundle_t        mem_q [DEPTH];
  logic [PW-1:0]  wr_q, rd_q;
  logic [CW-1:0]  cnt_q;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      if (pop_i)  rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      if (push_i && !pop_i)      cnt_q <= cnt_q + CW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CW'(1);
    end
  end

endmodule

/* hdl/tcsm_back.sv */
`timescale 1ns / 1ps

module tcsm_back import tcsm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  bundle_t     head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  action_o,
  output logic [31:0] out_seq_o,
  output logic [31:0] out_ack_o,
  output logic [15:0] out_len_o,
  output logic [3:0]  conn_state_out_o,
  output logic        last_o
);

  logic [1:0] k_q;
  res_t       cur;

  assign cur              = head_i.res[k_q];
  assign out_valid_o      = !empty_i;
  assign last_o           = (k_q == head_i.cnt - 2'd1);
  assign action_o         = cur.action;
  assign out_seq_o        = cur.seq;
  assign out_ack_o        = cur.ack;
  assign out_len_o        = cur.len;
  assign conn_state_out_o = head_i.conn_state;
  assign pop_o            = out_valid_o && out_ready_i && last_o;

  // advance through the item's results, rewind when the item retires
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= 2'd0;
    end else if (out_valid_o && out_ready_i) begin
      k_q <= last_o ? 2'd0 : k_q + 2'd1;
    end
  end

  a_cnt_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (head_i.cnt != 2'd0 && k_q < head_i.cnt))
    else $error("result index outside item");
  a_hold_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(k_q))
    else $error("result index moved while stalled");
  a_idle_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> k_q == 2'd0)
    else $error("result index not rewound");

endmodule

/* hdl/tcp_connection_state_machine_top.sv */
`timescale 1ns / 1ps

// Control block of one TCP connection.
// Input channel (in_valid_i/in_ready_o): one event per item - a received
// segment header, open, close, time-wait expiry or send-data request.
// Output channel (out_valid_o/out_ready_i): one or two result items per
// input item, the final one flagged by last_o.
// Configuration: cfg_we_i writes register cfg_idx_i (0 receive window,
// 1 passive open) from cfg_wdata_i; write only while idle.
// The front stage evaluates an event and updates the connection state in
// the cycle it is accepted; the bundle of results is registered into a
// two-entry queue whose head drives the outputs.
// Throughput is one input item per cycle while each item yields one result
// and the receiver is ready; the output side emits one result per cycle
// while out_ready_i is high, and an item retires with its last result.
// When the receiver stalls, results hold and the queue fills; in_ready_o
// falls once both entries are taken. Reset puts the connection in CLOSED
// with all sequence numbers zero and the receive window at 65535.
module tcp_connection_state_machine_top import tcsm_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  kind_i,
  input  logic [31:0] seg_seq_i,
  input  logic [31:0] seg_ack_i,
  input  logic        flag_syn_i,
  input  logic        flag_ack_i,
  input  logic        flag_fin_i,
  input  logic        flag_rst_i,
  input  logic [15:0] payload_len_i,
  input  logic [31:0] initial_seq_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  action_o,
  output logic [31:0] out_seq_o,
  output logic [31:0] out_ack_o,
  output logic [15:0] out_len_o,
  output logic [3:0]  conn_state_out_o,
  output logic        last_o
);

  logic    push, pop, full, empty;
  bundle_t push_data, head;

  tcsm_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .kind_i, .seg_seq_i, .seg_ack_i,
    .flag_syn_i, .flag_ack_i, .flag_fin_i, .flag_rst_i,
    .payload_len_i, .initial_seq_i,
    .q_full_i(full), .push_o(push), .push_data_o(push_data)
  );

  tcsm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i, .rst_ni, .push_i(push), .push_data_i(push_data), .pop_i(pop),
    .full_o(full), .empty_o(empty), .head_o(head)
  );

  tcsm_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .head_i(head), .pop_o(pop),
    .out_valid_o, .out_ready_i, .action_o, .out_seq_o, .out_ack_o,
    .out_len_o, .conn_state_out_o, .last_o
  );

endmodule
